@@ rtl/vsfc_pkg.sv @@
// Shared types and constants for the vector segment fraction check.
// No dependencies; imported by vector_segment_fraction_check.
`default_nettype none

package vsfc_pkg;

    // Coordinate and fraction defaults
    localparam int VALUE_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int COORD_FRAC_BITS   = 16;

    // Tolerance register, Q15.16 unsigned
    localparam int               TOL_BITS  = 31;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd66;

    // Result codes
    localparam logic [1:0] VERDICT_ON_SEGMENT  = 2'd0;
    localparam logic [1:0] VERDICT_OFF_SEGMENT = 2'd1;
    localparam logic [1:0] VERDICT_DEGENERATE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DEGEN,
        ST_PRE1,
        ST_PRE2,
        ST_DIV,
        ST_CLAMP,
        ST_AGREE,
        ST_FINISH
    } fsm_t;

endpackage

`default_nettype wire

@@ rtl/vector_segment_fraction_check.sv @@
// Point-on-segment check, one dimension per transfer, with a serial divider.
// Depends on vsfc_pkg for constants, result codes and the sequencer state type.
//
// Each input transfer carries one dimension (point, source, destination, signed
// fixed point with 16 fraction bits) and a last-dimension flag. A dimension whose
// source and destination coincide within the tolerance only checks the point;
// any other dimension computes r = (p - s) / (d - s) with a restoring divider
// that produces one quotient bit per clock, then clamps r into 0..1 and checks
// it against the first fraction of the vector. On the last dimension one result
// transfer gives the verdict and the fraction. A dimension that divides goes
// through ST_DIFF, ST_DEGEN, ST_PRE1, ST_PRE2, the ST_DIV steps, ST_CLAMP,
// ST_AGREE when it is checked against the first fraction, and ST_FINISH; it
// skips ST_AGREE when it sets the first fraction or fails the clamp. A quotient
// of two or more is rejected in ST_PRE2, a degenerate dimension goes from
// ST_DEGEN to ST_FINISH, and a dimension after a rejection goes from ST_IDLE
// straight to ST_FINISH. Input stall is high while a dimension is in work. A
// finished result sits in an output register, so the next dimension is taken
// while it waits; a last dimension holds in its final step until the output
// register is free. The tolerance may be written whenever cfg_ready is high.
`default_nettype none

module vector_segment_fraction_check #(
    parameter int VALUE_BITS    = vsfc_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = vsfc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic [vsfc_pkg::TOL_BITS-1:0] tolerance,

    input  wire logic                         in_valid,
    output      logic                         in_stall,
    input  wire logic signed [VALUE_BITS-1:0] point_value,
    input  wire logic signed [VALUE_BITS-1:0] source_value,
    input  wire logic signed [VALUE_BITS-1:0] dest_value,
    input  wire logic                         last_dimension,

    output      logic                         out_valid,
    input  wire logic                         out_stall,
    output      logic [1:0]                   verdict,
    output      logic [FRACTION_BITS:0]       fraction
);

    import vsfc_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int FB     = FRACTION_BITS;
    localparam int CW     = (VB > TOL_BITS) ? VB : TOL_BITS;
    localparam int TF_SHL = (FB >= COORD_FRAC_BITS) ? FB - COORD_FRAC_BITS : 0;
    localparam int TF_SHR = (FB >= COORD_FRAC_BITS) ? 0 : COORD_FRAC_BITS - FB;
    localparam int TFW    = TOL_BITS + TF_SHL;
    localparam int CNTW   = $clog2(FB);

    localparam logic [FB:0]     FRAC_ONE = (FB+1)'(1) << FB;
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(FB - 1);

    // {a < b, |a - b|} on sign-extended operands
    function automatic logic [VB:0] abs_diff(input logic [VB-1:0] a, input logic [VB-1:0] b);
        logic [VB:0] d;
        d = {a[VB-1], a} - {b[VB-1], b};
        if (d[VB])
            abs_diff = {1'b1, VB'(~d + 1'b1)};
        else
            abs_diff = {1'b0, d[VB-1:0]};
    endfunction

    fsm_t state_reg, state_next;

    logic [TOL_BITS-1:0] tol_reg;
    logic                rejected_reg;
    logic                frac_set_reg;
    logic [FB:0]         running_reg;

    logic                out_valid_reg;
    logic [1:0]          verdict_reg;
    logic [FB:0]         fraction_reg;

    // Datapath, no reset needed
    logic [VB-1:0]       p_reg, s_reg, d_reg;
    logic                last_reg;
    logic [VB-1:0]       den_reg, rem_reg, dp_reg, sp_reg;
    logic                nn_reg, nd_reg;
    logic [FB:0]         quo_reg;
    logic [FB:0]         r_reg;
    logic [CNTW-1:0]     cnt_reg;

    logic                in_xfer, out_xfer;
    logic [VB:0]         den_ad, num_ad, dp_ad, sp_ad;
    logic [TFW-1:0]      tol_f;
    logic                degen, degen_fail;
    logic                rem_ge_den;
    logic [VB-1:0]       rem_sub;
    logic [VB:0]         rem_dbl;
    logic                dbl_ge_den;
    logic                clamp_reject;
    logic [FB:0]         clamp_r;
    logic [FB:0]         gap;
    logic                agree_fail;
    logic                out_free;
    logic                result_load;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // last dimension finishing into a free output register
    assign result_load = (state_reg == ST_FINISH) && last_reg && out_free;

    assign den_ad = abs_diff(d_reg, s_reg);
    assign num_ad = abs_diff(p_reg, s_reg);
    assign dp_ad  = abs_diff(d_reg, p_reg);
    assign sp_ad  = abs_diff(s_reg, p_reg);

    assign tol_f = (TFW'(tol_reg) << TF_SHL) >> TF_SHR;

    assign degen      = CW'(den_reg) < CW'(tol_reg);
    assign degen_fail = (CW'(dp_reg) > CW'(tol_reg)) || (CW'(sp_reg) > CW'(tol_reg));

    // shared restoring step
    assign rem_ge_den = rem_reg >= den_reg;
    assign rem_sub    = rem_reg - den_reg;
    assign rem_dbl    = {rem_reg, 1'b0};
    assign dbl_ge_den = rem_dbl >= {1'b0, den_reg};

    always_comb
    begin
        clamp_reject = 1'b0;
        clamp_r      = quo_reg;
        if ((quo_reg != '0) && (nn_reg != nd_reg))
        begin
            // negative side: snap to zero when close enough
            if (TFW'(quo_reg) < tol_f)
                clamp_r = '0;
            else
                clamp_reject = 1'b1;
        end
        else if (quo_reg > FRAC_ONE)
        begin
            if (TFW'(quo_reg - FRAC_ONE) < tol_f)
                clamp_r = FRAC_ONE;
            else
                clamp_reject = 1'b1;
        end
    end

    assign gap        = (r_reg >= running_reg) ? r_reg - running_reg : running_reg - r_reg;
    assign agree_fail = TFW'(gap) > tol_f;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = rejected_reg ? ST_FINISH : ST_DIFF;
            end
            ST_DIFF:   state_next = ST_DEGEN;
            ST_DEGEN:  state_next = degen ? ST_FINISH : ST_PRE1;
            ST_PRE1:   state_next = ST_PRE2;
            ST_PRE2:   state_next = rem_ge_den ? ST_FINISH : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (clamp_reject || !frac_set_reg)
                    state_next = ST_FINISH;
                else
                    state_next = ST_AGREE;
            end
            ST_AGREE:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!last_reg || out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TOL_RESET;
            rejected_reg  <= 1'b0;
            frac_set_reg  <= 1'b0;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_ON_SEGMENT;
            fraction_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tol_reg <= tolerance;

            if (result_load)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_DEGEN:
                begin
                    if (degen && degen_fail)
                        rejected_reg <= 1'b1;
                end
                ST_PRE2:
                begin
                    if (rem_ge_den)
                        rejected_reg <= 1'b1;
                end
                ST_CLAMP:
                begin
                    if (clamp_reject)
                        rejected_reg <= 1'b1;
                    else if (!frac_set_reg)
                    begin
                        running_reg  <= clamp_r;
                        frac_set_reg <= 1'b1;
                    end
                end
                ST_AGREE:
                begin
                    if (agree_fail)
                        rejected_reg <= 1'b1;
                end
                ST_FINISH:
                begin
                    if (result_load)
                    begin
                        if (rejected_reg)
                        begin
                            verdict_reg  <= VERDICT_OFF_SEGMENT;
                            fraction_reg <= '0;
                        end
                        else if (!frac_set_reg)
                        begin
                            verdict_reg  <= VERDICT_DEGENERATE;
                            fraction_reg <= '0;
                        end
                        else
                        begin
                            verdict_reg  <= VERDICT_ON_SEGMENT;
                            fraction_reg <= running_reg;
                        end
                        rejected_reg <= 1'b0;
                        frac_set_reg <= 1'b0;
                        running_reg  <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    p_reg    <= point_value;
                    s_reg    <= source_value;
                    d_reg    <= dest_value;
                    last_reg <= last_dimension;
                end
            end
            ST_DIFF:
            begin
                den_reg <= den_ad[VB-1:0];
                nd_reg  <= den_ad[VB];
                rem_reg <= num_ad[VB-1:0];
                nn_reg  <= num_ad[VB];
                dp_reg  <= dp_ad[VB-1:0];
                sp_reg  <= sp_ad[VB-1:0];
            end
            ST_PRE1:
            begin
                // integer bit of the quotient
                if (rem_ge_den)
                begin
                    rem_reg <= rem_sub;
                    quo_reg <= (FB+1)'(1);
                end
                else
                    quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                if (dbl_ge_den)
                begin
                    rem_reg <= VB'(rem_dbl - {1'b0, den_reg});
                    quo_reg <= {quo_reg[FB-1:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_dbl[VB-1:0];
                    quo_reg <= {quo_reg[FB-1:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_CLAMP:
            begin
                r_reg <= clamp_r;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign fraction  = fraction_reg;

endmodule

`default_nettype wire
